// ===== hw/rtl/dsfs_pkg.sv =====
package dsfs_pkg;

	// field widths
	localparam int unsigned FREQ_W   = 22;
	localparam int unsigned CYC_W    = 4;
	localparam int unsigned PERIOD_W = 16;
	localparam int unsigned TYPE_W   = 2;
	localparam int unsigned CFG_IDX_W = 1;

	// request kinds
	localparam logic [TYPE_W-1:0] REQ_UP   = 2'd0;
	localparam logic [TYPE_W-1:0] REQ_DOWN = 2'd1;
	localparam logic [TYPE_W-1:0] REQ_LOAD = 2'd2;

	// configuration register indexes
	localparam logic [CFG_IDX_W-1:0] CFG_MIN = 1'd0;
	localparam logic [CFG_IDX_W-1:0] CFG_MAX = 1'd1;

	// reset values
	localparam logic [FREQ_W-1:0] FREQ_RESET = 22'd100000;
	localparam logic [FREQ_W-1:0] MIN_RESET  = 22'd191;
	localparam logic [FREQ_W-1:0] MAX_RESET  = 22'd3125000;

	// buffer cycle thresholds
	localparam logic [FREQ_W-1:0] CYC2_AT = 22'd97656;
	localparam logic [FREQ_W-1:0] CYC4_AT = 22'd195313;
	localparam logic [FREQ_W-1:0] CYC8_AT = 22'd390625;

	// timer division
	localparam int unsigned NUM_W = 24;
	localparam int unsigned DIV_W = 19;
	localparam logic [NUM_W-1:0] CLOCK_NUM = 24'd12500000;
	localparam logic [NUM_W-1:0] PER_FLOOR = 24'd31;
	localparam logic [NUM_W-1:0] PER_CEIL  = 24'd65535;

	// decade step sizes
	localparam int unsigned STEP_W = 14;

	function automatic logic [STEP_W-1:0] up_amount(input logic [FREQ_W-1:0] f);
		logic [STEP_W-1:0] a;
		if (f < 22'd1000) a = 14'd1;
		else if (f < 22'd10000) a = 14'd10;
		else if (f < 22'd100000) a = 14'd100;
		else if (f < 22'd1000000) a = 14'd1000;
		else a = 14'd10000;
		return a;
	endfunction

	function automatic logic [STEP_W-1:0] down_amount(input logic [FREQ_W-1:0] f);
		logic [STEP_W-1:0] a;
		if (f <= 22'd1000) a = 14'd1;
		else if (f <= 22'd10000) a = 14'd10;
		else if (f <= 22'd100000) a = 14'd100;
		else if (f <= 22'd1000000) a = 14'd1000;
		else a = 14'd10000;
		return a;
	endfunction

endpackage

// ===== hw/rtl/decade_step_frequency_setter.sv =====
// sequence: an accepted request passes the prepare step, 24 division steps
// and the finish step before its result is valid; a zero divisor skips to the result
// throughput: one request at a time; req_stall holds new requests until the result
// is taken, and most of that span is spent in the 24-step restoring divider
// reset: target 100000, limits 191 and 3125000, idle with no result pending
module decade_step_frequency_setter (
	input  logic                                 clk,
	input  logic                                 arst_n,
	input  logic                                 req_valid,
	output logic                                 req_stall,
	input  logic [dsfs_pkg::TYPE_W-1:0]          req_type,
	input  logic [dsfs_pkg::FREQ_W-1:0]          set_value,
	output logic                                 res_valid,
	input  logic                                 res_stall,
	output logic [dsfs_pkg::FREQ_W-1:0]          target_frequency,
	output logic [dsfs_pkg::CYC_W-1:0]           cycles_per_buffer,
	output logic [dsfs_pkg::PERIOD_W-1:0]        timer_period,
	input  logic                                 cfg_we,
	input  logic [dsfs_pkg::CFG_IDX_W-1:0]       cfg_index,
	input  logic [dsfs_pkg::FREQ_W-1:0]          cfg_data
);

	localparam logic [2:0] ST_IDLE = 3'd0;
	localparam logic [2:0] ST_PREP = 3'd1;
	localparam logic [2:0] ST_DIV  = 3'd2;
	localparam logic [2:0] ST_FIN  = 3'd3;
	localparam logic [2:0] ST_OUT  = 3'd4;

	localparam int unsigned DIV_STEPS = dsfs_pkg::NUM_W;
	localparam int unsigned CNT_W = $clog2(DIV_STEPS);
	localparam logic [CNT_W-1:0] CNT_LAST = CNT_W'(DIV_STEPS - 1);

	logic [2:0]                          state_q;
	logic [dsfs_pkg::FREQ_W-1:0]         min_q;
	logic [dsfs_pkg::FREQ_W-1:0]         max_q;
	logic [dsfs_pkg::FREQ_W-1:0]         freq_q;
	logic [dsfs_pkg::CYC_W-1:0]          cyc_q;
	logic [dsfs_pkg::PERIOD_W-1:0]       period_q;
	logic [dsfs_pkg::DIV_W-1:0]          div_q;
	logic [dsfs_pkg::DIV_W-1:0]          rem_q;
	logic [dsfs_pkg::NUM_W-1:0]          quo_q;
	logic [CNT_W-1:0]                    cnt_q;

	logic                                req_take;
	logic signed [dsfs_pkg::FREQ_W+1:0]  next_v;
	logic [dsfs_pkg::FREQ_W-1:0]         next_freq;
	logic [1:0]                          shift;
	logic [dsfs_pkg::FREQ_W-1:0]         scaled;
	logic [dsfs_pkg::DIV_W:0]            rem_shift;
	logic                                rem_ge;
	logic [dsfs_pkg::DIV_W:0]            rem_diff;
	logic [dsfs_pkg::NUM_W-1:0]          quo_m1;
	logic [dsfs_pkg::PERIOD_W-1:0]       period_fin;

	assign req_take  = req_valid && !req_stall;
	assign req_stall = (state_q != ST_IDLE);

	// new target before saturation
	always_comb begin
		case (req_type)
			dsfs_pkg::REQ_UP:
				next_v = $signed({2'b00, freq_q}) +
					$signed({10'd0, dsfs_pkg::up_amount(freq_q)});
			dsfs_pkg::REQ_DOWN:
				next_v = $signed({2'b00, freq_q}) -
					$signed({10'd0, dsfs_pkg::down_amount(freq_q)});
			dsfs_pkg::REQ_LOAD:
				next_v = $signed({2'b00, set_value});
			default:
				next_v = $signed({2'b00, freq_q});
		endcase
	end

	// saturate into the limits, minimum wins
	always_comb begin
		if (next_v < $signed({2'b00, min_q})) begin
			next_freq = min_q;
		end else if (next_v > $signed({2'b00, max_q})) begin
			next_freq = max_q;
		end else begin
			next_freq = next_v[dsfs_pkg::FREQ_W-1:0];
		end
	end

	// cycles per buffer as a shift
	always_comb begin
		if (freq_q < dsfs_pkg::CYC2_AT) shift = 2'd0;
		else if (freq_q < dsfs_pkg::CYC4_AT) shift = 2'd1;
		else if (freq_q < dsfs_pkg::CYC8_AT) shift = 2'd2;
		else shift = 2'd3;
		scaled = freq_q >> shift;
	end

	// one restoring division step
	always_comb begin
		rem_shift = {rem_q, quo_q[dsfs_pkg::NUM_W-1]};
		rem_ge    = (rem_shift >= {1'b0, div_q});
		rem_diff  = rem_shift - {1'b0, div_q};
	end

	// quotient minus one, floored and saturated
	always_comb begin
		quo_m1 = quo_q - dsfs_pkg::NUM_W'(1);
		if (quo_q == '0) begin
			period_fin = dsfs_pkg::PER_FLOOR[dsfs_pkg::PERIOD_W-1:0];
		end else if (quo_m1 < dsfs_pkg::PER_FLOOR) begin
			period_fin = dsfs_pkg::PER_FLOOR[dsfs_pkg::PERIOD_W-1:0];
		end else if (quo_m1 > dsfs_pkg::PER_CEIL) begin
			period_fin = dsfs_pkg::PER_CEIL[dsfs_pkg::PERIOD_W-1:0];
		end else begin
			period_fin = quo_m1[dsfs_pkg::PERIOD_W-1:0];
		end
	end

	// configuration registers
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			min_q <= dsfs_pkg::MIN_RESET;
			max_q <= dsfs_pkg::MAX_RESET;
		end else if (cfg_we) begin
			case (cfg_index)
				dsfs_pkg::CFG_MIN: min_q <= cfg_data;
				dsfs_pkg::CFG_MAX: max_q <= cfg_data;
				default: ;
			endcase
		end
	end

	// sequencer and target
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= ST_IDLE;
			freq_q  <= dsfs_pkg::FREQ_RESET;
			cnt_q   <= '0;
		end else begin
			case (state_q)
				ST_IDLE: begin
					if (req_take) begin
						freq_q  <= next_freq;
						state_q <= ST_PREP;
					end
				end
				ST_PREP: begin
					cnt_q <= '0;
					if (scaled == '0) begin
						state_q <= ST_OUT;
					end else begin
						state_q <= ST_DIV;
					end
				end
				ST_DIV: begin
					cnt_q <= cnt_q + CNT_W'(1);
					if (cnt_q == CNT_LAST) begin
						state_q <= ST_FIN;
					end
				end
				ST_FIN: begin
					state_q <= ST_OUT;
				end
				ST_OUT: begin
					if (!res_stall) begin
						state_q <= ST_IDLE;
					end
				end
				default: begin
					state_q <= ST_IDLE;
				end
			endcase
		end
	end

	// divider datapath and result registers
	always_ff @(posedge clk) begin
		case (state_q)
			ST_PREP: begin
				cyc_q <= dsfs_pkg::CYC_W'(1) << shift;
				div_q <= scaled[dsfs_pkg::DIV_W-1:0];
				rem_q <= '0;
				quo_q <= dsfs_pkg::CLOCK_NUM;
				period_q <= dsfs_pkg::PER_CEIL[dsfs_pkg::PERIOD_W-1:0];
			end
			ST_DIV: begin
				if (rem_ge) begin
					rem_q <= rem_diff[dsfs_pkg::DIV_W-1:0];
				end else begin
					rem_q <= rem_shift[dsfs_pkg::DIV_W-1:0];
				end
				quo_q <= {quo_q[dsfs_pkg::NUM_W-2:0], rem_ge};
			end
			ST_FIN: begin
				period_q <= period_fin;
			end
			default: ;
		endcase
	end

	assign res_valid         = (state_q == ST_OUT);
	assign target_frequency  = freq_q;
	assign cycles_per_buffer = cyc_q;
	assign timer_period      = period_q;

	// an accepted request always starts the prepare step
	a_take_prep: assert property (@(posedge clk) disable iff (!arst_n)
		req_take |=> state_q == ST_PREP)
		else $error("accepted request did not start");

	// the divider never runs with a zero divisor
	a_div_nonzero: assert property (@(posedge clk) disable iff (!arst_n)
		state_q == ST_DIV |-> div_q != '0)
		else $error("division by zero");

	// cycles per buffer is a single power of two
	a_cyc_onehot: assert property (@(posedge clk) disable iff (!arst_n)
		res_valid |-> $onehot(cycles_per_buffer))
		else $error("cycles per buffer not a power of two");

	// period floor holds
	a_period_floor: assert property (@(posedge clk) disable iff (!arst_n)
		res_valid |-> timer_period >= dsfs_pkg::PER_FLOOR[dsfs_pkg::PERIOD_W-1:0])
		else $error("timer period below floor");

	// target lies in ordered limits
	a_target_range: assert property (@(posedge clk) disable iff (!arst_n)
		res_valid && (min_q <= max_q) |->
			target_frequency >= min_q && target_frequency <= max_q)
		else $error("target outside limits");

endmodule
